// ===== rtl/core/sfla_pkg.sv =====
package sfla_pkg;

  // fixed field widths
  localparam int ADDR_W      = 16;
  localparam int OBJ_W       = 13;
  localparam int COUNT_W     = 15;
  localparam int PAGE_CNT_W  = 5;

  // defaults for the top level parameters
  localparam int DEF_MAX_PAGES = 16;
  localparam int DEF_PAGE_SIZE = 4096;

  // object size after reset, and the smallest size that takes effect
  localparam logic [OBJ_W-1:0] OBJ_RESET = OBJ_W'(16);
  localparam logic [OBJ_W-1:0] OBJ_MIN   = OBJ_W'(4);

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_PAGE  = 2'd1,
    STAT_BAD_ADDR = 2'd2,
    STAT_DBL_FREE = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAP,
    ST_HEAD_RD,
    ST_ALLOC_CHK,
    ST_OPEN,
    ST_POP_RD,
    ST_POP_WB,
    ST_ADDR,
    ST_PG_SCAN,
    ST_IDX_DIV,
    ST_WALK_INIT,
    ST_WALK,
    ST_WALK_WAIT,
    ST_PUSH,
    ST_FINISH
  } state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/slab_free_list_allocator.sv =====
// Slab allocator over a pool of MAX_PAGES pages of PAGE_SIZE bytes each. A request is an
// allocate (pops the free-list head of the newest page, opening a new page when that one is
// full) or a free (pushes the slot back onto its own page's list after checking that the
// address lies in an open page, on a slot boundary, and is not already free). The free lists
// live in two synchronous RAMs with one write and one read port each (list heads per page,
// links per slot); slots of the newest page at or above a fresh mark are never written and
// read back as the in-order chain, so opening a page costs no fill pass. Items are handled
// one at a time. An allocate reads the page head, checks it, reads and writes back the link
// of the taken slot and forms the address; a page open comes first when the newest page is
// full, and the very first one divides the page size by the slot size on the bit-serial
// divider (16 bits wide at the default page size). A free finds the page by repeated
// subtraction, divides the offset by the slot size, reads the page head and walks the
// page's free list for the double-free check (up to slots per page entries) before the
// push; a rejected free returns sooner. The next request is taken once a result is in the
// output register, also while it waits there; a second result stalls until the first has
// left. Slot size writes are ignored once any page has been opened.
module slab_free_list_allocator import sfla_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int PAGE_SIZE = DEF_PAGE_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [ADDR_W-1:0]     in_free_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [ADDR_W-1:0]     out_alloc_address,
  output logic [COUNT_W-1:0]    out_used_count,
  output logic [PAGE_CNT_W-1:0] out_page_count,
  output logic [COUNT_W-1:0]    out_total_slots,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [OBJ_W-1:0]      cfg_slot_size
);

  localparam int SLOTS_MAX = PAGE_SIZE / 4;
  localparam int SW        = $clog2(SLOTS_MAX);
  localparam int LW        = $clog2(SLOTS_MAX + 1);
  localparam int PW        = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int PB_W      = $clog2(PAGE_SIZE + 1);
  localparam int DIV_W     = (PB_W > ADDR_W) ? PB_W : ADDR_W;
  localparam int PROD_W    = LW + OBJ_W;
  localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(PAGE_SIZE);

  // sequencer and request registers
  state_t              state_r, state_nxt;
  logic                req_r, req_nxt;
  status_t             status_r, status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;

  // allocator state
  logic [CNT_W-1:0]    pages_r, pages_nxt;
  logic [COUNT_W-1:0]  slots_r, slots_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [LW-1:0]       cap_r, cap_nxt;
  logic [LW-1:0]       w_r, w_nxt;
  logic [OBJ_W-1:0]    obj_r, obj_nxt;

  // per-request working registers
  logic [LW-1:0]       hd_r, hd_nxt;
  logic [LW-1:0]       i_r, i_nxt;
  logic [LW-1:0]       idx_r, idx_nxt;
  logic [LW-1:0]       steps_r, steps_nxt;
  logic [PW-1:0]       pg_r, pg_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [DIV_W-1:0]    off_r, off_nxt;
  logic [CNT_W-1:0]    pgc_r, pgc_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [COUNT_W-1:0]  out_used_r, out_used_nxt;
  logic [CNT_W-1:0]    out_pages_r, out_pages_nxt;
  logic [COUNT_W-1:0]  out_total_r, out_total_nxt;

  // memory and divider hookup
  logic                head_we;
  logic [PW-1:0]       head_waddr, head_raddr;
  logic [LW-1:0]       head_wdata, head_rdata;
  logic                link_we;
  logic [PW+SW-1:0]    link_waddr, link_raddr;
  logic [LW-1:0]       link_wdata, link_rdata;
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend, div_divisor, div_quo, div_rem;
  div_stat_t           div_stat;

  logic [OBJ_W-1:0]    obj_eff;
  logic [PW-1:0]       newest_pg;
  logic [LW-1:0]       pop_link;

  assign obj_eff   = (obj_r < OBJ_MIN) ? OBJ_MIN : obj_r;
  assign newest_pg = PW'(pages_r - CNT_W'(1));
  // slots at or above the fresh mark of the newest page chain to the next slot
  assign pop_link  = (hd_r >= w_r) ? hd_r + LW'(1) : link_rdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  sfla_ram #(.ADDR_W(PW), .DATA_W(LW)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  sfla_ram #(.ADDR_W(PW + SW), .DATA_W(LW)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  sfla_div #(.W(DIV_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // next state, memory and divider control
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    status_nxt     = status_r;
    res_addr_nxt   = res_addr_r;
    pages_nxt      = pages_r;
    slots_nxt      = slots_r;
    total_nxt      = total_r;
    base_nxt       = base_r;
    cap_nxt        = cap_r;
    w_nxt          = w_r;
    obj_nxt        = obj_r;
    hd_nxt         = hd_r;
    i_nxt          = i_r;
    idx_nxt        = idx_r;
    steps_nxt      = steps_r;
    pg_nxt         = pg_r;
    prod_nxt       = prod_r;
    off_nxt        = off_r;
    pgc_nxt        = pgc_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_used_nxt   = out_used_r;
    out_pages_nxt  = out_pages_r;
    out_total_nxt  = out_total_r;

    head_we      = 1'b0;
    head_waddr   = newest_pg;
    head_wdata   = pop_link;
    head_raddr   = (req_r == REQ_FREE) ? pg_r : newest_pg;
    link_we      = 1'b0;
    link_waddr   = {pg_r, idx_r[SW-1:0]};
    link_wdata   = hd_r;
    link_raddr   = {pg_r, i_r[SW-1:0]};
    div_start    = 1'b0;
    div_dividend = DIV_W'(PAGE_SIZE);
    div_divisor  = DIV_W'(obj_eff);

    // result beat leaves the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // register write, only before the first page opens
    if (cfg_valid && pages_r == '0) begin
      obj_nxt = cfg_slot_size;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_req_type;
          status_nxt   = STAT_OK;
          res_addr_nxt = '0;
          if (in_req_type == REQ_FREE) begin
            off_nxt   = DIV_W'(in_free_address);
            pgc_nxt   = '0;
            state_nxt = ST_PG_SCAN;
          end else if (pages_r == '0) begin
            div_start = 1'b1;
            state_nxt = ST_CAP;
          end else begin
            state_nxt = ST_HEAD_RD;
          end
        end
      end

      // slots per page for the first page
      ST_CAP: begin
        if (div_stat.done) begin
          cap_nxt   = (div_quo == '0) ? LW'(1) : LW'(div_quo);
          state_nxt = ST_OPEN;
        end
      end

      ST_HEAD_RD: begin
        state_nxt = (req_r == REQ_FREE) ? ST_WALK_INIT : ST_ALLOC_CHK;
      end

      ST_ALLOC_CHK: begin
        if (head_rdata < cap_r) begin
          hd_nxt    = head_rdata;
          state_nxt = ST_POP_RD;
        end else if (pages_r >= CNT_W'(MAX_PAGES)) begin
          status_nxt = STAT_NO_PAGE;
          state_nxt  = ST_FINISH;
        end else begin
          state_nxt = ST_OPEN;
        end
      end

      // new page: whole chain is fresh
      ST_OPEN: begin
        pages_nxt = pages_r + CNT_W'(1);
        base_nxt  = (pages_r == '0) ? '0 : base_r + PAGE_STEP;
        total_nxt = total_r + COUNT_W'(cap_r);
        w_nxt     = '0;
        hd_nxt    = '0;
        state_nxt = ST_POP_RD;
      end

      ST_POP_RD: begin
        link_raddr = {newest_pg, hd_r[SW-1:0]};
        state_nxt  = ST_POP_WB;
      end

      // pop: head moves to the link of the taken slot
      ST_POP_WB: begin
        head_we    = 1'b1;
        head_waddr = newest_pg;
        head_wdata = pop_link;
        if (hd_r >= w_r) begin
          w_nxt = hd_r + LW'(1);
        end
        slots_nxt = slots_r + COUNT_W'(1);
        prod_nxt  = PROD_W'(hd_r) * PROD_W'(obj_eff);
        state_nxt = ST_ADDR;
      end

      ST_ADDR: begin
        res_addr_nxt = base_r + prod_r[ADDR_W-1:0];
        state_nxt    = ST_FINISH;
      end

      // page number of the freed address, one page size subtracted per cycle
      ST_PG_SCAN: begin
        if (pgc_r >= pages_r) begin
          status_nxt = STAT_BAD_ADDR;
          state_nxt  = ST_FINISH;
        end else if (off_r < DIV_W'(PAGE_SIZE)) begin
          pg_nxt       = PW'(pgc_r);
          div_start    = 1'b1;
          div_dividend = off_r;
          state_nxt    = ST_IDX_DIV;
        end else begin
          off_nxt = off_r - DIV_W'(PAGE_SIZE);
          pgc_nxt = pgc_r + CNT_W'(1);
        end
      end

      // slot index, must be on a boundary and below the page capacity
      ST_IDX_DIV: begin
        if (div_stat.done) begin
          if (div_rem != '0 || div_quo >= DIV_W'(cap_r)) begin
            status_nxt = STAT_BAD_ADDR;
            state_nxt  = ST_FINISH;
          end else begin
            idx_nxt   = LW'(div_quo);
            state_nxt = ST_HEAD_RD;
          end
        end
      end

      ST_WALK_INIT: begin
        hd_nxt    = head_rdata;
        i_nxt     = head_rdata;
        steps_nxt = '0;
        state_nxt = ST_WALK;
      end

      // double-free check, one chain entry per pass through ST_WALK and ST_WALK_WAIT
      ST_WALK: begin
        if (i_r >= cap_r || steps_r >= cap_r) begin
          state_nxt = ST_PUSH;
        end else if (i_r == idx_r) begin
          status_nxt = STAT_DBL_FREE;
          state_nxt  = ST_FINISH;
        end else begin
          link_raddr = {pg_r, i_r[SW-1:0]};
          state_nxt  = ST_WALK_WAIT;
        end
      end

      ST_WALK_WAIT: begin
        if (pg_r == newest_pg && i_r >= w_r) begin
          i_nxt = i_r + LW'(1);
        end else begin
          i_nxt = link_rdata;
        end
        steps_nxt = steps_r + LW'(1);
        state_nxt = ST_WALK;
      end

      // push the slot onto its page list
      ST_PUSH: begin
        link_we    = 1'b1;
        link_waddr = {pg_r, idx_r[SW-1:0]};
        link_wdata = hd_r;
        head_we    = 1'b1;
        head_waddr = pg_r;
        head_wdata = idx_r;
        if (slots_r != '0) begin
          slots_nxt = slots_r - COUNT_W'(1);
        end
        state_nxt = ST_FINISH;
      end

      // load the result beat once the output register is free
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_addr_nxt   = res_addr_r;
          out_used_nxt   = slots_r;
          out_pages_nxt  = pages_r;
          out_total_nxt  = total_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pages_r     <= '0;
      slots_r     <= '0;
      total_r     <= '0;
      base_r      <= '0;
      obj_r       <= OBJ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pages_r     <= pages_nxt;
      slots_r     <= slots_nxt;
      total_r     <= total_nxt;
      base_r      <= base_nxt;
      obj_r       <= obj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    status_r     <= status_nxt;
    res_addr_r   <= res_addr_nxt;
    cap_r        <= cap_nxt;
    w_r          <= w_nxt;
    hd_r         <= hd_nxt;
    i_r          <= i_nxt;
    idx_r        <= idx_nxt;
    steps_r      <= steps_nxt;
    pg_r         <= pg_nxt;
    prod_r       <= prod_nxt;
    off_r        <= off_nxt;
    pgc_r        <= pgc_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_used_r   <= out_used_nxt;
    out_pages_r  <= out_pages_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_alloc_address = out_addr_r;
  assign out_used_count    = out_used_r;
  assign out_page_count    = PAGE_CNT_W'(out_pages_r);
  assign out_total_slots   = out_total_r;

  // open pages never exceed the pool
  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pages_r <= CNT_W'(MAX_PAGES))
    else $error("page count beyond pool size");

  // used count moves only on a pop or a push
  a_slots_change: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(slots_r) |-> $past(state_r == ST_POP_WB) || $past(state_r == ST_PUSH))
    else $error("used count changed outside pop or push");

  // divider runs only while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_CAP || state_r == ST_IDX_DIV)
    else $error("divider busy outside a division state");

  // fresh mark stays within the page
  a_fresh_mark: assert property (@(posedge clk) disable iff (!rst_n)
    pages_r != '0 |-> w_r <= cap_r)
    else $error("fresh mark beyond page capacity");

endmodule

// ===== rtl/core/sfla_ram.sv =====
module sfla_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sfla_div.sv =====
module sfla_div import sfla_pkg::*; #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output div_stat_t    stat
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       trial;
  logic [W:0]       diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[W]) begin
          rem_r <= diff[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= trial[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

endmodule

// ===== sim/tb_slab_free_list_allocator.sv =====
module tb_slab_free_list_allocator import sfla_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAGES  = DEF_MAX_PAGES;
  localparam int PAGE_SIZE  = DEF_PAGE_SIZE;
  localparam int SLOT_LIMIT = PAGE_SIZE / 4;

  // one expected result beat
  typedef struct packed {
    status_t                 status;
    logic [ADDR_W-1:0]       address;
    logic [COUNT_W-1:0]      used;
    logic [PAGE_CNT_W-1:0]   pages;
    logic [COUNT_W-1:0]      total;
  } slab_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [ADDR_W-1:0]     in_free_address;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_status;
  logic [ADDR_W-1:0]     out_alloc_address;
  logic [COUNT_W-1:0]    out_used_count;
  logic [PAGE_CNT_W-1:0] out_page_count;
  logic [COUNT_W-1:0]    out_total_slots;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [OBJ_W-1:0]      cfg_slot_size;

  // allocator state as the testbench tracks it
  logic [10:0]           slot_link [MAX_PAGES*SLOT_LIMIT];
  logic [10:0]           page_head [MAX_PAGES];
  logic [PAGE_CNT_W-1:0] open_pages;
  logic [COUNT_W-1:0]    slots_used;
  logic [OBJ_W-1:0]      object_bytes;

  slab_result_t      pending_results[$];
  logic [ADDR_W-1:0] live_slots[$];
  logic [ADDR_W-1:0] freed_slots[$];

  int errors = 0;
  int printed = 0;
  int results_seen = 0;
  int items_sent = 0;
  int status_seen [4] = '{default: 0};
  bit steady_flow = 1'b0;
  int rx_hold_cycles = 0;

  slab_free_list_allocator #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_SIZE (PAGE_SIZE)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_alloc_address (out_alloc_address),
    .out_used_count    (out_used_count),
    .out_page_count    (out_page_count),
    .out_total_slots   (out_total_slots),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_slot_size     (cfg_slot_size)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // slot size in effect, small sizes raised to the minimum
  function automatic int unsigned slot_size();
    return (object_bytes < OBJ_MIN) ? int'(OBJ_MIN) : int'(object_bytes);
  endfunction

  function automatic int unsigned page_slots();
    int unsigned c;
    c = PAGE_SIZE / slot_size();
    return (c == 0) ? 1 : c;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // update the tracked pool for one request and build its result
  function automatic slab_result_t apply_request(input logic kind,
                                                 input logic [ADDR_W-1:0] addr);
    slab_result_t r;
    int unsigned  obj, cap, p, off, idx, i, steps;
    bit           have;
    obj = slot_size();
    cap = page_slots();
    r = '0;
    r.status = STAT_OK;
    if (kind == REQ_ALLOC) begin
      have = 1'b0;
      if (open_pages != '0) have = page_head[open_pages - 1] < cap;
      // newest page empty or none yet: open the next one with an in-order chain
      if (!have) begin
        if (open_pages >= MAX_PAGES) begin
          r.status = STAT_NO_PAGE;
        end else begin
          p = open_pages;
          for (i = 0; i < cap; i++) slot_link[p*SLOT_LIMIT + i] = 11'(i + 1);
          page_head[p] = '0;
          open_pages++;
          have = 1'b1;
        end
      end
      // pop the head of the newest page
      if (have) begin
        p = open_pages - 1;
        idx = page_head[p];
        page_head[p] = slot_link[p*SLOT_LIMIT + idx];
        slots_used++;
        r.address = ADDR_W'(p * PAGE_SIZE + idx * obj);
      end
    end else begin
      p = addr / PAGE_SIZE;
      off = addr % PAGE_SIZE;
      idx = off / obj;
      if (p >= open_pages || off % obj != 0 || idx >= cap) begin
        r.status = STAT_BAD_ADDR;
      end else begin
        // walk the page's free chain looking for the slot
        i = page_head[p];
        steps = 0;
        while (i < cap && steps < cap && r.status == STAT_OK) begin
          if (i == idx) begin
            r.status = STAT_DBL_FREE;
          end else begin
            i = slot_link[p*SLOT_LIMIT + i];
            steps++;
          end
        end
        if (r.status == STAT_OK) begin
          slot_link[p*SLOT_LIMIT + idx] = page_head[p];
          page_head[p] = 11'(idx);
          if (slots_used != '0) slots_used--;
        end
      end
    end
    r.used  = slots_used;
    r.pages = open_pages;
    r.total = COUNT_W'(open_pages * cap);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (printed < 40) begin
      printed++;
      $display("[%0t] %s: got %0d, expected %0d (result %0d)",
               $time, what, got, want, results_seen);
    end
  endtask

  // drive one request beat, record what it should return once taken
  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr);
    int           gap;
    int           hit[$];
    slab_result_t want;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_free_address <= ADDR_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_free_address <= addr;
    do @(posedge clk); while (!in_ready);
    want = apply_request(kind, addr);
    pending_results.push_back(want);
    items_sent++;
    // keep the sets of live and recently freed slots current
    if (want.status == STAT_OK) begin
      if (kind == REQ_ALLOC) begin
        live_slots.push_back(want.address);
      end else begin
        hit = live_slots.find_first_index(x) with (x == addr);
        if (hit.size() != 0) live_slots.delete(hit[0]);
        freed_slots.push_back(addr);
        if (freed_slots.size() > 8) void'(freed_slots.pop_front());
      end
    end
    @(negedge clk);
  endtask

  // mostly well-formed traffic, some broken frees and noise
  task automatic send_random_item();
    int unsigned       r, p, cap, obj;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    obj = slot_size();
    cap = page_slots();
    a = ADDR_W'($urandom);
    if (r < 55 || (r < 80 && live_slots.size() == 0)) begin
      send_request(REQ_ALLOC, a);
    end else if (r < 80) begin
      send_request(REQ_FREE, live_slots[$urandom_range(0, live_slots.size() - 1)]);
    end else if (r < 87 && freed_slots.size() != 0) begin
      send_request(REQ_FREE, freed_slots[$urandom_range(0, freed_slots.size() - 1)]);
    end else if (r < 95 && open_pages != '0) begin
      // slot boundary in an open page, one past the end included
      p = $urandom_range(0, open_pages - 1);
      a = ADDR_W'(p * PAGE_SIZE + $urandom_range(0, cap) * obj);
      send_request(REQ_FREE, a);
    end else begin
      send_request(REQ_FREE, a);
    end
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch("results never returned", 0, pending_results.size());
      pending_results.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  // one config beat, ignored by the block once a page is open
  task automatic write_slot_size(input logic [OBJ_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_slot_size <= value;
    do @(posedge clk); while (!cfg_ready);
    if (open_pages == '0) object_bytes = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_slot_size_setup();
    logic [OBJ_W-1:0] working;
    case ($urandom_range(0, 9))
      0:       working = OBJ_W'(3);
      1:       working = OBJ_W'(8191);
      2:       working = OBJ_W'(4096);
      3:       working = OBJ_W'(1000);
      4, 5:    working = OBJ_W'(100);
      6, 7:    working = OBJ_W'(256);
      8:       working = OBJ_W'(48);
      default: working = OBJ_W'(24);
    endcase
    write_slot_size('0);
    write_slot_size('1);
    write_slot_size(working);
  endtask

  task automatic test_directed();
    int unsigned obj, cap, k;
    obj = slot_size();
    cap = page_slots();
    send_request(REQ_FREE, '0);                    // no page open yet
    send_request(REQ_ALLOC, '1);                   // opens page 0
    send_request(REQ_ALLOC, '0);
    send_request(REQ_FREE, ADDR_W'(obj));          // back onto page 0
    send_request(REQ_FREE, ADDR_W'(obj));          // already free
    send_request(REQ_FREE, ADDR_W'(obj + 1));      // off a slot boundary
    send_request(REQ_FREE, '1);                    // top of the pool, page closed
    send_request(REQ_FREE, ADDR_W'(cap * obj));    // one past the last slot
    send_request(REQ_ALLOC, 16'h5555);
    // fill page 0 so page 1 opens, then hand an old slot back
    if (cap <= 12) begin
      for (k = 0; k < cap; k++) send_request(REQ_ALLOC, 16'haaaa);
      send_request(REQ_FREE, '0);
      send_request(REQ_ALLOC, '0);
    end
    // one slot per page: run out of pages
    if (cap <= 1) begin
      for (k = 0; k < MAX_PAGES; k++) send_request(REQ_ALLOC, '0);
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    int k;
    rx_hold_cycles = 300;
    for (k = 0; k < 12; k++) send_random_item();
    drain_results();
  endtask

  task automatic test_steady_stream();
    int k;
    steady_flow = 1'b1;
    for (k = 0; k < 100; k++) send_random_item();
    steady_flow = 1'b0;
    drain_results();
  endtask

  task automatic test_late_size_write();
    int k;
    write_slot_size(OBJ_W'($urandom));
    write_slot_size(OBJ_MIN);
    for (k = 0; k < 20; k++) send_random_item();
    drain_results();
  endtask

  task automatic test_random_traffic(input int n);
    int k;
    k = 0;
    while (k < n) begin
      // now and then a run of allocations to push toward a full pool
      if ($urandom_range(0, 63) == 0) begin
        repeat (16) send_request(REQ_ALLOC, ADDR_W'($urandom));
        k += 16;
      end else begin
        send_random_item();
        k++;
      end
    end
    drain_results();
  endtask

  // result side: random stalls, plus a long hold when asked
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end else if (!steady_flow && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // compare each result beat with the oldest expectation
  initial begin
    slab_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", out_status, 0);
        end else begin
          want = pending_results.pop_front();
          status_seen[int'(want.status)]++;
          if (out_status != want.status)
            report_mismatch("status", out_status, want.status);
          if (out_alloc_address != want.address)
            report_mismatch("alloc_address", out_alloc_address, want.address);
          if (out_used_count != want.used)
            report_mismatch("used_count", out_used_count, want.used);
          if (out_page_count != want.pages)
            report_mismatch("page_count", out_page_count, want.pages);
          if (out_total_slots != want.total)
            report_mismatch("total_slots", out_total_slots, want.total);
        end
      end
    end
  end

  initial begin
    #250ms;
    $display("timeout: requests stopped moving");
    $display("slab_free_list_allocator: mismatch");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_ALLOC;
    in_free_address = '0;
    cfg_valid = 1'b0;
    cfg_slot_size = '0;
    open_pages = '0;
    slots_used = '0;
    object_bytes = OBJ_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_slot_size_setup();
    test_directed();
    test_backpressure();
    test_steady_stream();
    test_late_size_write();
    test_random_traffic(1000);

    drain_results();
    repeat (64) @(negedge clk);
    $display("run: %0d requests on %0d-byte slots, %0d per page, %0d pages opened",
             items_sent, slot_size(), page_slots(), open_pages);
    $display("run: ok %0d, no page %0d, bad address %0d, double free %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("slab_free_list_allocator: match");
    end else begin
      $display("slab_free_list_allocator: mismatch");
    end
    $finish;
  end

endmodule
